// ===== rtl/core/spx_pkg.sv =====
// ----------------------------------------------------------------------------
// spx_pkg: shared types and constants of the simplex projection block
// Holds the fixed field widths and the command/status bundles that pass
// between the controller and the datapath.
// ----------------------------------------------------------------------------
package spx_pkg;

	// Fixed widths of the stream fields.
	localparam int WEIGHT_W = 32;
	localparam int PROJ_W   = 25;
	localparam int POS_W    = 6;
	localparam int S_DATA_W = 32;
	localparam int M_DATA_W = 32;

	// Width of the exact running sums, products and the shared divider.
	localparam int ACC_W      = 64;
	localparam int STEP_W     = 7;
	localparam int WIDE_STEPS = 64;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic start;      // latch the overflow flag and clear the rank search
		logic run_clear;  // empty the store for the next vector
		logic rd_k;       // read the store at the outer index
		logic rd_j;       // read the store at the inner index
		logic k_lat;      // capture the outer element
		logic j_clr;      // rewind the inner index
		logic j_acc;      // add the inner element to the rank sums
		logic mul;        // form the rank product and the shifted sum
		logic cmp;        // test the rank condition and step the outer index
		logic th_init;    // load the divider for the threshold
		logic div_step;   // run one step of the divider
		logic th_fin;     // capture the threshold
		logic v_acc;      // add one clamped difference to the sum
		logic o_set;      // set up one result
		logic o_lat;      // capture the divider quotient as the result
		logic o_next;     // step to the next result
	} spx_cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic empty;      // no element was stored in this vector
		logic k_last;     // the outer index is at the last element
		logic j_last;     // the inner index is at the last element
		logic div_last;   // the divider runs its final step
		logic need_div;   // the current result needs a division
	} spx_stat_t;

	// Controller states, one-hot.
	typedef enum logic [17:0] {
		ST_LOAD  = 18'h00001,
		ST_START = 18'h00002,
		ST_KRD   = 18'h00004,
		ST_KLAT  = 18'h00008,
		ST_JRD   = 18'h00010,
		ST_JACC  = 18'h00020,
		ST_MUL   = 18'h00040,
		ST_CMP   = 18'h00080,
		ST_THS   = 18'h00100,
		ST_THD   = 18'h00200,
		ST_THF   = 18'h00400,
		ST_VRD   = 18'h00800,
		ST_VACC  = 18'h01000,
		ST_ORD   = 18'h02000,
		ST_OSET  = 18'h04000,
		ST_ODIV  = 18'h08000,
		ST_OLAT  = 18'h10000,
		ST_OSEND = 18'h20000
	} spx_state_t;

endpackage

// ===== rtl/core/simplex_projection.sv =====
// ----------------------------------------------------------------------------
// simplex_projection: Euclidean projection onto the probability simplex
// Collects a vector of Q8.24 weights and returns its projection in Q1.24.
// ----------------------------------------------------------------------------
// Weights arrive one per cycle on the slave stream, the element with tlast
// ending the vector; up to MAX_ELEMENTS are kept and further ones are dropped
// and reported through tuser on every result. After the vector ends, input
// is held off while the block ranks each element against all the others
// through the single read port of the weight store, divides for the threshold
// on a one-bit-per-cycle divider, sums the clamped differences and then
// produces one result per element in input order, running the divider only
// for a result that needs a division. A new vector is accepted once the last
// result has been taken.
module simplex_projection #(
	parameter int MAX_ELEMENTS = 64,
	parameter int FRAC_BITS    = 24
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          s_tvalid,
	output logic                          s_tready,
	input  logic [spx_pkg::S_DATA_W-1:0]  s_tdata,   // [31:0] weight
	input  logic                          s_tlast,
	output logic                          m_tvalid,
	input  logic                          m_tready,
	output logic [spx_pkg::M_DATA_W-1:0]  m_tdata,   // [24:0] projected, [30:25] position
	output logic                          m_tlast,
	output logic                          m_tuser    // [0] truncated
);

	spx_pkg::spx_cmd_t  cmd;
	spx_pkg::spx_stat_t st;
	logic in_fire, out_fire;
	logic [spx_pkg::PROJ_W-1:0] proj;
	logic [spx_pkg::POS_W-1:0]  pos;

	assign in_fire  = s_tvalid && s_tready;
	assign out_fire = m_tvalid && m_tready;

	// Sequencer.
	spx_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_fire   (in_fire),
		.in_last   (s_tlast),
		.out_fire  (out_fire),
		.st        (st),
		.cmd       (cmd),
		.in_ready  (s_tready),
		.out_valid (m_tvalid)
	);

	// Store and arithmetic.
	spx_dp #(
		.MAX_ELEMENTS (MAX_ELEMENTS),
		.FRAC_BITS    (FRAC_BITS)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_fire   (in_fire),
		.in_weight (s_tdata[spx_pkg::WEIGHT_W-1:0]),
		.cmd       (cmd),
		.st        (st),
		.out_proj  (proj),
		.out_pos   (pos),
		.out_final (m_tlast),
		.out_trunc (m_tuser)
	);

	// Pack the result fields, lowest first.
	assign m_tdata = {
		(spx_pkg::M_DATA_W - spx_pkg::PROJ_W - spx_pkg::POS_W)'(0), pos, proj};

	// Input and output never overlap.
	a_no_overlap: assert property (@(posedge clk) disable iff (!arst_n)
		!(s_tready && m_tvalid))
		else $error("input and output open together");

	// The end of a vector closes the input.
	a_last_closes: assert property (@(posedge clk) disable iff (!arst_n)
		(s_tvalid && s_tready && s_tlast) |=> !s_tready)
		else $error("input stayed open after the last element");

	// The final result reopens the input.
	a_final_reopens: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && m_tready && m_tlast) |=> s_tready)
		else $error("input not reopened after the final result");

endmodule

// ===== rtl/core/spx_ctrl.sv =====
// ----------------------------------------------------------------------------
// spx_ctrl: sequencer of the simplex projection
// Steps through loading, the rank search, the threshold division, the sum of
// clamped differences and the per-element normalization.
// ----------------------------------------------------------------------------
module spx_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_fire,
	input  logic              in_last,
	input  logic              out_fire,
	input  spx_pkg::spx_stat_t st,
	output spx_pkg::spx_cmd_t  cmd,
	output logic              in_ready,
	output logic              out_valid
);

	spx_pkg::spx_state_t state_q, state_d;

	// State register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= spx_pkg::ST_LOAD;
		end else begin
			state_q <= state_d;
		end
	end

	assign in_ready  = (state_q == spx_pkg::ST_LOAD);
	assign out_valid = (state_q == spx_pkg::ST_OSEND);

	// Next state and command decode.
	always_comb begin
		state_d = state_q;
		cmd     = '0;
		case (state_q)
			spx_pkg::ST_LOAD: begin
				if (in_fire && in_last) state_d = spx_pkg::ST_START;
			end
			spx_pkg::ST_START: begin
				if (st.empty) begin
					cmd.run_clear = 1'b1;
					state_d       = spx_pkg::ST_LOAD;
				end else begin
					cmd.start = 1'b1;
					state_d   = spx_pkg::ST_KRD;
				end
			end
			spx_pkg::ST_KRD: begin
				cmd.rd_k = 1'b1;
				state_d  = spx_pkg::ST_KLAT;
			end
			spx_pkg::ST_KLAT: begin
				cmd.k_lat = 1'b1;
				cmd.j_clr = 1'b1;
				state_d   = spx_pkg::ST_JRD;
			end
			spx_pkg::ST_JRD: begin
				cmd.rd_j = 1'b1;
				state_d  = spx_pkg::ST_JACC;
			end
			spx_pkg::ST_JACC: begin
				cmd.j_acc = 1'b1;
				state_d   = st.j_last ? spx_pkg::ST_MUL : spx_pkg::ST_JRD;
			end
			spx_pkg::ST_MUL: begin
				cmd.mul = 1'b1;
				state_d = spx_pkg::ST_CMP;
			end
			spx_pkg::ST_CMP: begin
				cmd.cmp = 1'b1;
				state_d = st.k_last ? spx_pkg::ST_THS : spx_pkg::ST_KRD;
			end
			spx_pkg::ST_THS: begin
				cmd.th_init = 1'b1;
				state_d     = spx_pkg::ST_THD;
			end
			spx_pkg::ST_THD: begin
				cmd.div_step = 1'b1;
				if (st.div_last) state_d = spx_pkg::ST_THF;
			end
			spx_pkg::ST_THF: begin
				cmd.th_fin = 1'b1;
				cmd.j_clr  = 1'b1;
				state_d    = spx_pkg::ST_VRD;
			end
			spx_pkg::ST_VRD: begin
				cmd.rd_j = 1'b1;
				state_d  = spx_pkg::ST_VACC;
			end
			spx_pkg::ST_VACC: begin
				cmd.v_acc = 1'b1;
				if (st.j_last) begin
					cmd.j_clr = 1'b1;
					state_d   = spx_pkg::ST_ORD;
				end else begin
					state_d = spx_pkg::ST_VRD;
				end
			end
			spx_pkg::ST_ORD: begin
				cmd.rd_j = 1'b1;
				state_d  = spx_pkg::ST_OSET;
			end
			spx_pkg::ST_OSET: begin
				cmd.o_set = 1'b1;
				state_d   = st.need_div ? spx_pkg::ST_ODIV : spx_pkg::ST_OSEND;
			end
			spx_pkg::ST_ODIV: begin
				cmd.div_step = 1'b1;
				if (st.div_last) state_d = spx_pkg::ST_OLAT;
			end
			spx_pkg::ST_OLAT: begin
				cmd.o_lat = 1'b1;
				state_d   = spx_pkg::ST_OSEND;
			end
			spx_pkg::ST_OSEND: begin
				if (out_fire) begin
					cmd.o_next = 1'b1;
					if (st.j_last) begin
						cmd.run_clear = 1'b1;
						state_d       = spx_pkg::ST_LOAD;
					end else begin
						state_d = spx_pkg::ST_ORD;
					end
				end
			end
			default: begin
				state_d = spx_pkg::ST_LOAD;
			end
		endcase
	end

endmodule

// ===== rtl/core/spx_dp.sv =====
// ----------------------------------------------------------------------------
// spx_dp: datapath of the simplex projection
// Weight store, rank sums, threshold, clamped sum and a shared restoring
// divider that produces one quotient bit per cycle.
// ----------------------------------------------------------------------------
module spx_dp #(
	parameter int MAX_ELEMENTS = 64,
	parameter int FRAC_BITS    = 24
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_fire,
	input  logic [spx_pkg::WEIGHT_W-1:0]  in_weight,
	input  spx_pkg::spx_cmd_t             cmd,
	output spx_pkg::spx_stat_t            st,
	output logic [spx_pkg::PROJ_W-1:0]    out_proj,
	output logic [spx_pkg::POS_W-1:0]     out_pos,
	output logic                          out_final,
	output logic                          out_trunc
);

	localparam int CNT_W = $clog2(MAX_ELEMENTS + 1);
	localparam int IDX_W = (MAX_ELEMENTS > 1) ? $clog2(MAX_ELEMENTS) : 1;
	localparam int AW    = spx_pkg::ACC_W;
	localparam logic [AW-1:0] ONE = AW'(1) << FRAC_BITS;

	// Weight store and its registered read port.
	logic signed [spx_pkg::WEIGHT_W-1:0] mem [MAX_ELEMENTS];
	logic signed [spx_pkg::WEIGHT_W-1:0] rdata_q;

	logic [CNT_W-1:0] n_q, k_q, j_q, cnt_q, best_cnt_q;
	logic             ovf_q, trunc_q;
	logic signed [spx_pkg::WEIGHT_W-1:0] wk_q;
	logic signed [AW-1:0] sum_q, best_sum_q, prod_q, diff_q, theta_q, vsum_q;

	// Divider state.
	logic [AW:0]        rem_q;
	logic [AW-1:0]      dvd_q, quo_q, den_q;
	logic [spx_pkg::STEP_W-1:0] steps_q;
	logic               neg_q;
	logic [spx_pkg::PROJ_W-1:0] proj_q;

	logic                 store_free;
	logic signed [AW-1:0] rd_ext, v_cur, th_num, th_mag;
	logic signed [spx_pkg::WEIGHT_W+CNT_W:0] prod_w;
	logic [AW:0]          rem_sh;
	logic                 rem_ge;

	assign store_free = (n_q < CNT_W'(MAX_ELEMENTS));
	assign rd_ext     = AW'(rdata_q);
	assign v_cur      = rd_ext - theta_q;
	assign th_num     = best_sum_q - $signed(ONE);
	assign th_mag     = th_num[AW-1] ? (-th_num + AW'(best_cnt_q) - AW'(1)) : th_num;
	assign rem_sh     = {rem_q[AW-1:0], dvd_q[AW-1]};
	assign rem_ge     = (rem_sh >= {1'b0, den_q});

	// Rank product, exact at the full width of count times weight.
	assign prod_w = $signed({1'b0, cnt_q}) * wk_q;

	// Status toward the controller.
	assign st.empty    = (n_q == '0);
	assign st.k_last   = (k_q + CNT_W'(1) == n_q);
	assign st.j_last   = (j_q + CNT_W'(1) == n_q);
	assign st.div_last = (steps_q == spx_pkg::STEP_W'(1));
	assign st.need_div = (vsum_q > 0) ? ((v_cur > 0) && (v_cur < vsum_q)) : 1'b1;

	// Store write on accepted items and read at the outer or inner index.
	always_ff @(posedge clk) begin
		if (in_fire && store_free) mem[n_q[IDX_W-1:0]] <= in_weight;
		if (cmd.rd_k) rdata_q <= mem[k_q[IDX_W-1:0]];
		else if (cmd.rd_j) rdata_q <= mem[j_q[IDX_W-1:0]];
	end

	// Element count and overflow flag.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			n_q     <= '0;
			ovf_q   <= 1'b0;
			trunc_q <= 1'b0;
		end else begin
			if (in_fire) begin
				if (store_free) n_q <= n_q + CNT_W'(1);
				else ovf_q <= 1'b1;
			end
			if (cmd.start) begin
				trunc_q <= ovf_q;
				ovf_q   <= 1'b0;
			end
			if (cmd.run_clear) begin
				n_q   <= '0;
				ovf_q <= 1'b0;
			end
		end
	end

	// Rank search: for each element, count and sum all elements not below it.
	always_ff @(posedge clk) begin
		if (cmd.start) begin
			k_q        <= '0;
			best_cnt_q <= '0;
			best_sum_q <= '0;
		end
		if (cmd.k_lat) begin
			wk_q  <= rdata_q;
			cnt_q <= '0;
			sum_q <= '0;
		end
		if (cmd.j_clr) j_q <= '0;
		else if (cmd.j_acc || cmd.v_acc || cmd.o_next) j_q <= j_q + CNT_W'(1);
		if (cmd.j_acc && (rdata_q >= wk_q)) begin
			cnt_q <= cnt_q + CNT_W'(1);
			sum_q <= sum_q + rd_ext;
		end
		if (cmd.mul) begin
			prod_q <= AW'(prod_w);
			diff_q <= sum_q - $signed(ONE);
		end
		// A tie block shares one condition; keep the deepest rank that passes.
		if (cmd.cmp) begin
			k_q <= k_q + CNT_W'(1);
			if ((prod_q > diff_q) && (cnt_q > best_cnt_q)) begin
				best_cnt_q <= cnt_q;
				best_sum_q <= sum_q;
			end
		end
		if (cmd.th_fin) begin
			theta_q <= neg_q ? -$signed(quo_q) : $signed(quo_q);
			vsum_q  <= '0;
		end
		if (cmd.v_acc && (v_cur > 0)) vsum_q <= vsum_q + v_cur;
	end

	// Shared restoring divider and result register.
	always_ff @(posedge clk) begin
		if (cmd.th_init) begin
			rem_q   <= '0;
			dvd_q   <= th_mag;
			den_q   <= AW'(best_cnt_q);
			quo_q   <= '0;
			neg_q   <= th_num[AW-1];
			steps_q <= spx_pkg::STEP_W'(spx_pkg::WIDE_STEPS);
		end
		if (cmd.o_set) begin
			quo_q <= '0;
			if (vsum_q > 0) begin
				rem_q   <= {1'b0, v_cur};
				dvd_q   <= '0;
				den_q   <= vsum_q;
				steps_q <= spx_pkg::STEP_W'(FRAC_BITS);
				if (v_cur <= 0) proj_q <= '0;
				else proj_q <= ONE[spx_pkg::PROJ_W-1:0];
			end else begin
				// Uniform share when the clamped sum is not positive.
				rem_q   <= '0;
				dvd_q   <= ONE;
				den_q   <= AW'(n_q);
				steps_q <= spx_pkg::STEP_W'(spx_pkg::WIDE_STEPS);
			end
		end
		if (cmd.div_step) begin
			rem_q   <= rem_ge ? (rem_sh - {1'b0, den_q}) : rem_sh;
			quo_q   <= {quo_q[AW-2:0], rem_ge};
			dvd_q   <= {dvd_q[AW-2:0], 1'b0};
			steps_q <= steps_q - spx_pkg::STEP_W'(1);
		end
		if (cmd.o_lat) proj_q <= quo_q[spx_pkg::PROJ_W-1:0];
	end

	assign out_proj  = proj_q;
	assign out_pos   = spx_pkg::POS_W'(j_q);
	assign out_final = st.j_last;
	assign out_trunc = trunc_q;

endmodule

// ===== sim/tb_simplex_projection.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_simplex_projection: self-checking bench for the simplex projection block
// Streams weight vectors into the block, predicts each projected element with
// exact integer arithmetic and checks every output transfer against it, while
// both stream sides idle and stall at random.
// ----------------------------------------------------------------------------
module tb_simplex_projection;

	localparam int  STORE_DEPTH = 64;
	localparam int  FRAC        = 24;
	localparam longint ONE_Q    = 64'sd1 << FRAC;
	localparam int  STALL_LIMIT = 60000;
	localparam int  HOLD_CYCLES = 1500;

	typedef struct {
		logic [31:0] weight;
		logic        last;
		logic        drain;   // wait for every outstanding result first
	} weight_item_t;

	typedef struct {
		logic [spx_pkg::PROJ_W-1:0] projected;
		logic [spx_pkg::POS_W-1:0]  position;
		logic                       final_res;
		logic                       truncated;
	} proj_result_t;

	logic clk;
	logic arst_n;
	logic s_tvalid;
	logic s_tready;
	logic [spx_pkg::S_DATA_W-1:0] s_tdata;
	logic s_tlast;
	logic m_tvalid;
	logic m_tready;
	logic [spx_pkg::M_DATA_W-1:0] m_tdata;
	logic m_tlast;
	logic m_tuser;

	weight_item_t pending_items[$];
	proj_result_t expected_proj[$];
	int           vec_weights[$];
	logic         vec_dropped;
	int           accepted_items;
	int           error_count;
	int           stall_cycles;
	int           hold_left;
	logic         hold_done;

	simplex_projection dut (
		.clk(clk), .arst_n(arst_n),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tlast(s_tlast),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tlast(m_tlast),
		.m_tuser(m_tuser)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// floor(num * 2^FRAC / den) by restoring long division, for 0 <= num <= den.
	function automatic longint unsigned frac_quotient(longint unsigned num,
			longint unsigned den);
		longint unsigned q;
		longint unsigned r;
		q = 0;
		r = num;
		if (r >= den)
			return longint'(1) << FRAC;
		for (int b = 0; b < FRAC; b++) begin
			r = r << 1;
			q = q << 1;
			if (r >= den) begin
				r = r - den;
				q = q | 1;
			end
		end
		return q;
	endfunction

	// Projects the collected vector and queues one expectation per element.
	task automatic project_vector();
		int     ranked[STORE_DEPTH];
		int     n;
		int     j;
		int     rho;
		longint csum;
		longint csum_rho;
		longint num;
		longint den;
		longint theta;
		longint vsum;
		longint diff;
		longint unsigned p;
		proj_result_t res;
		n = vec_weights.size();
		// Descending insertion sort of the stored weights.
		for (int i = 0; i < n; i++) begin
			j = i;
			while (j > 0 && ranked[j-1] < vec_weights[i]) begin
				ranked[j] = ranked[j-1];
				j--;
			end
			ranked[j] = vec_weights[i];
		end
		// Largest rank that still satisfies the support condition.
		csum = 0;
		csum_rho = 0;
		rho = 0;
		for (int i = 0; i < n; i++) begin
			csum += ranked[i];
			if (longint'(ranked[i]) * longint'(i + 1) > csum - ONE_Q) begin
				rho = i;
				csum_rho = csum;
			end
		end
		num = csum_rho - ONE_Q;
		den = rho + 1;
		theta = (num >= 0) ? num / den : -((-num + den - 1) / den);
		vsum = 0;
		for (int i = 0; i < n; i++) begin
			diff = longint'(vec_weights[i]) - theta;
			if (diff > 0)
				vsum += diff;
		end
		for (int i = 0; i < n; i++) begin
			diff = longint'(vec_weights[i]) - theta;
			if (vsum > 0)
				p = (diff > 0) ? frac_quotient(diff, vsum) : 0;
			else
				p = longint'(ONE_Q) / n;
			res.projected = p[spx_pkg::PROJ_W-1:0];
			res.position  = i[spx_pkg::POS_W-1:0];
			res.final_res = (i + 1 == n);
			res.truncated = vec_dropped;
			expected_proj.push_back(res);
		end
	endtask

	// Tracks one accepted weight transfer.
	task automatic accept_weight(logic [31:0] w, logic last);
		if (vec_weights.size() < STORE_DEPTH)
			vec_weights.push_back(int'(w));
		else
			vec_dropped = 1'b1;
		if (last) begin
			if (vec_weights.size() > 0)
				project_vector();
			vec_weights.delete();
			vec_dropped = 1'b0;
		end
	endtask

	task automatic report(string what, logic [31:0] got, logic [31:0] want);
		$display("mismatch: %s got %0h expected %0h at %0t", what, got, want, $realtime);
		error_count++;
	endtask

	task automatic add_item(logic [31:0] w, logic last, logic drain = 1'b0);
		weight_item_t it;
		it.weight = w;
		it.last   = last;
		it.drain  = drain;
		pending_items.push_back(it);
	endtask

	function automatic logic [31:0] rand_weight();
		case ($urandom_range(0, 2))
			0: return $urandom;
			1: return $urandom_range(0, 32'h0800_0000) - 32'h0400_0000;
			default: return 32'h0100_0000 + $urandom_range(0, 255) - 128;
		endcase
	endfunction

	task automatic add_random_vector(int len, logic drain = 1'b0);
		for (int i = 0; i < len; i++)
			add_item(rand_weight(), i == len - 1, drain && i == 0);
	endtask

	// Sender: offers pending items, idling at random by phase of the run.
	always @(posedge clk or negedge arst_n) begin : driver
		logic offer;
		logic pause;
		int   idle_pct;
		if (!arst_n) begin
			s_tvalid <= 1'b0;
			s_tdata  <= '0;
			s_tlast  <= 1'b0;
		end else begin
			offer = s_tvalid;
			if (s_tvalid && s_tready) begin
				accept_weight(s_tdata, s_tlast);
				accepted_items++;
				offer = 1'b0;
			end
			if (!offer && pending_items.size() > 0) begin
				idle_pct = (accepted_items < 70) ? 34 : (accepted_items < 140) ? 88 : 0;
				pause = pending_items[0].drain && expected_proj.size() > 0;
				if (!pause && $urandom_range(0, 99) >= idle_pct) begin
					s_tdata <= pending_items[0].weight;
					s_tlast <= pending_items[0].last;
					void'(pending_items.pop_front());
					offer = 1'b1;
				end
			end
			s_tvalid <= offer;
		end
	end

	// Receiver: random stalls by phase, plus one long hold-off.
	always @(posedge clk or negedge arst_n) begin : receiver
		int stall_pct;
		if (!arst_n) begin
			m_tready  <= 1'b0;
			hold_left <= 0;
			hold_done <= 1'b0;
		end else if (hold_left > 0) begin
			m_tready  <= 1'b0;
			hold_left <= hold_left - 1;
		end else if (!hold_done && accepted_items >= 30) begin
			m_tready  <= 1'b0;
			hold_left <= HOLD_CYCLES;
			hold_done <= 1'b1;
		end else begin
			stall_pct = (accepted_items < 70) ? 88 : (accepted_items < 140) ? 34 : 0;
			m_tready <= ($urandom_range(0, 99) >= stall_pct);
		end
	end

	// Result checker and stall watchdog.
	always @(posedge clk) begin : monitor
		proj_result_t want;
		if (arst_n) begin
			if (m_tvalid && m_tready) begin
				if (expected_proj.size() == 0) begin
					report("unexpected result", m_tdata, 0);
				end else begin
					want = expected_proj.pop_front();
					if (m_tdata[24:0] !== want.projected)
						report("projected", m_tdata[24:0], want.projected);
					if (m_tdata[30:25] !== want.position)
						report("position", m_tdata[30:25], want.position);
					if (m_tlast !== want.final_res)
						report("final", m_tlast, want.final_res);
					if (m_tuser !== want.truncated)
						report("truncated", m_tuser, want.truncated);
				end
			end
			if ((m_tvalid && m_tready) || (s_tvalid && s_tready))
				stall_cycles <= 0;
			else
				stall_cycles <= stall_cycles + 1;
			if (stall_cycles >= STALL_LIMIT) begin
				$display("RESULT: ERROR");
				$finish;
			end
		end
	end

	initial begin
		arst_n         = 1'b0;
		accepted_items = 0;
		error_count    = 0;
		stall_cycles   = 0;
		vec_dropped    = 1'b0;

		// Directed vectors: field extremes, ties, zeros, mixed signs.
		add_item(32'h7FFF_FFFF, 1'b1);
		add_item(32'h8000_0000, 1'b1);
		add_item(32'h0100_0000, 1'b0);
		add_item(32'h0000_0000, 1'b1);
		add_item(32'h8000_0000, 1'b0);
		add_item(32'h7FFF_FFFF, 1'b1);
		add_item(32'h0080_0000, 1'b0);
		add_item(32'h0080_0000, 1'b0);
		add_item(32'h0080_0000, 1'b1);
		repeat (4) add_item(32'h0000_0000, 1'b0);
		add_item(32'h0000_0000, 1'b1);
		add_item(32'hFF00_0000, 1'b0);
		add_item(32'h0300_0000, 1'b0);
		add_item(32'h0040_0000, 1'b0);
		add_item(32'hFFC0_0000, 1'b0);
		add_item(32'h0000_0001, 1'b1);
		add_item(32'hFFFF_FFFF, 1'b0);
		add_item(32'h8000_0001, 1'b1, 1'b1);

		// Full store, then an overflowing vector whose last three items are dropped.
		add_random_vector(64);
		for (int i = 0; i < 67; i++)
			add_item(rand_weight(), i == 66, i == 0);
		while (pending_items.size() < 200)
			add_random_vector($urandom_range(1, 8), $urandom_range(0, 9) == 0);
		add_random_vector(3, 1'b1);

		repeat (6) @(posedge clk);
		arst_n = 1'b1;

		wait (pending_items.size() == 0 && !s_tvalid && expected_proj.size() == 0);
		repeat (300) @(posedge clk);
		if (error_count == 0 && expected_proj.size() == 0)
			$display("RESULT: OK");
		else
			$display("RESULT: ERROR");
		$finish;
	end

endmodule
